// ===== rtl/mosl_pkg.sv =====
// shared constants, types and codes for the median-of-two-sorted-lists block
// no dependencies; every other file refers to this package by scoped names
`default_nettype none

package mosl_pkg;

	localparam int LIST_DEPTH  = 64;
	localparam int ADDR_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W       = ADDR_W + 1;
	localparam int TOTAL_W     = CNT_W + 1;
	localparam int VALUE_W     = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// command codes on the input channel
	localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
	localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
	localparam logic [1:0] CMD_MEDIAN        = 2'd2;

	// status codes on the result channel
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_EMPTY   = 2'd1;
	localparam logic [1:0] STATUS_DROPPED = 2'd2;

	typedef enum logic [1:0] {
		OP_APPEND_FIRST,
		OP_APPEND_SECOND,
		OP_MEDIAN
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic signed [VALUE_W-1:0]  value;
	} job_t;

endpackage

`default_nettype wire

// ===== rtl/mosl_item_if.sv =====
// input channel: command and value words under a valid/ready handshake
// depends on mosl_pkg for the value width
`default_nettype none

interface mosl_item_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           command;
	logic signed [mosl_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/mosl_result_if.sv =====
// result channel: median, half flag and status under a valid/ready handshake
// depends on mosl_pkg for the value width
`default_nettype none

interface mosl_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [mosl_pkg::VALUE_W-1:0]  median;
	logic                                 has_half;
	logic [1:0]                           status;

	modport source (output valid, output median, output has_half, output status, input ready);
	modport sink   (input valid, input median, input has_half, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/mosl_front.sv =====
// front end: takes input words, decodes the command and drops unused codes
// depends on mosl_pkg and mosl_item_if
`default_nettype none

module mosl_front (
	mosl_item_if.sink         item,
	output logic              push_valid,
	input  logic              push_ready,
	output mosl_pkg::job_t    push_job
);

	logic cmd_known;

	always_comb begin
		cmd_known   = 1'b1;
		push_job.op = mosl_pkg::OP_MEDIAN;
		unique case (item.command)
			mosl_pkg::CMD_APPEND_FIRST:  push_job.op = mosl_pkg::OP_APPEND_FIRST;
			mosl_pkg::CMD_APPEND_SECOND: push_job.op = mosl_pkg::OP_APPEND_SECOND;
			mosl_pkg::CMD_MEDIAN:        push_job.op = mosl_pkg::OP_MEDIAN;
			default:                     cmd_known   = 1'b0;
		endcase
		push_job.value = item.value;
	end

	// unused command codes are taken and discarded without using a slot
	assign item.ready = push_ready;
	assign push_valid = item.valid && cmd_known;

endmodule

`default_nettype wire

// ===== rtl/mosl_queue.sv =====
// short job queue between the front end and the list engine
// depends on mosl_pkg
`default_nettype none

module mosl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  mosl_pkg::job_t    push_job,
	output logic              pop_valid,
	input  logic              pop_ready,
	output mosl_pkg::job_t    pop_job
);

	mosl_pkg::job_t               entries_q [mosl_pkg::QUEUE_DEPTH];
	logic [mosl_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [mosl_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [mosl_pkg::QPTR_W:0]    fill_q;
	logic                         push_fire;
	logic                         pop_fire;

	assign push_ready = (fill_q != (mosl_pkg::QPTR_W+1)'(mosl_pkg::QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_job    = entries_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_fire) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (mosl_pkg::QPTR_W+1)'(mosl_pkg::QUEUE_DEPTH))
		else $error("queue fill beyond depth");

	a_fill_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push_fire && !pop_fire) |=> fill_q == $past(fill_q) + 1'b1)
		else $error("queue fill did not follow a push");

endmodule

`default_nettype wire

// ===== rtl/mosl_back.sv =====
// list engine: two list memories, append handling, merge walk and result register
// depends on mosl_pkg and mosl_result_if
`default_nettype none

module mosl_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  mosl_pkg::job_t    job,
	mosl_result_if.source     result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam int VW = mosl_pkg::VALUE_W;
	localparam int CW = mosl_pkg::CNT_W;
	localparam int AW = mosl_pkg::ADDR_W;
	localparam int TW = mosl_pkg::TOTAL_W;

	logic signed [VW-1:0]  first_mem  [mosl_pkg::LIST_DEPTH];
	logic signed [VW-1:0]  second_mem [mosl_pkg::LIST_DEPTH];

	logic [1:0]            state_q;
	logic [CW-1:0]         cnt1_q;
	logic [CW-1:0]         cnt2_q;
	logic                  dropped_q;
	logic [CW-1:0]         i1_q;
	logic [CW-1:0]         i2_q;
	logic [CW-1:0]         k_q;
	logic [CW-1:0]         mid_q;
	logic                  odd_q;
	logic                  empty_q;
	logic signed [VW-1:0]  rd1_q;
	logic signed [VW-1:0]  rd2_q;
	logic signed [VW-1:0]  prev_q;
	logic signed [VW-1:0]  cur_q;
	logic                  out_valid_q;
	logic signed [VW-1:0]  median_q;
	logic                  half_q;
	logic [1:0]            status_q;

	logic [TW-1:0]         total;
	logic                  take_first;
	logic [CW-1:0]         i1_next;
	logic [CW-1:0]         i2_next;
	logic [AW-1:0]         rd_addr1;
	logic [AW-1:0]         rd_addr2;
	logic                  wr1;
	logic                  wr2;
	logic                  first_room;
	logic                  second_room;
	logic [VW:0]           sum;
	logic [VW:0]           sum_adj;
	logic                  load_out;
	logic                  job_fire;

	assign job_ready   = (state_q == ST_IDLE);
	assign job_fire    = job_valid && job_ready;
	assign total       = {1'b0, cnt1_q} + {1'b0, cnt2_q};
	assign first_room  = (cnt1_q < CW'(mosl_pkg::LIST_DEPTH));
	assign second_room = (cnt2_q < CW'(mosl_pkg::LIST_DEPTH));
	assign wr1 = job_fire && (job.op == mosl_pkg::OP_APPEND_FIRST) && first_room;
	assign wr2 = job_fire && (job.op == mosl_pkg::OP_APPEND_SECOND) && second_room;

	// first list wins ties; a spent list is never compared
	assign take_first = (i1_q < cnt1_q) && ((i2_q >= cnt2_q) || (rd1_q <= rd2_q));
	assign i1_next    = i1_q + CW'(take_first);
	assign i2_next    = i2_q + CW'(!take_first);
	assign rd_addr1   = (state_q == ST_WALK) ? i1_next[AW-1:0] : '0;
	assign rd_addr2   = (state_q == ST_WALK) ? i2_next[AW-1:0] : '0;

	// mean of the middle pair, truncated toward zero
	assign sum     = {prev_q[VW-1], prev_q} + {cur_q[VW-1], cur_q};
	assign sum_adj = sum + (VW+1)'(sum[VW]);

	assign load_out = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	always_ff @(posedge clk) begin
		if (wr1) begin
			first_mem[cnt1_q[AW-1:0]] <= job.value;
		end
		if (wr2) begin
			second_mem[cnt2_q[AW-1:0]] <= job.value;
		end
		rd1_q <= first_mem[rd_addr1];
		rd2_q <= second_mem[rd_addr2];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WALK) begin
			prev_q <= cur_q;
			cur_q  <= take_first ? rd1_q : rd2_q;
		end
		if (load_out) begin
			if (empty_q) begin
				median_q <= '0;
				half_q   <= 1'b0;
				status_q <= mosl_pkg::STATUS_EMPTY;
			end else begin
				median_q <= odd_q ? cur_q : sum_adj[VW:1];
				half_q   <= !odd_q && sum[0];
				status_q <= dropped_q ? mosl_pkg::STATUS_DROPPED : mosl_pkg::STATUS_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt1_q      <= '0;
			cnt2_q      <= '0;
			dropped_q   <= 1'b0;
			i1_q        <= '0;
			i2_q        <= '0;
			k_q         <= '0;
			mid_q       <= '0;
			odd_q       <= 1'b0;
			empty_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_fire) begin
						unique case (job.op)
							mosl_pkg::OP_APPEND_FIRST: begin
								if (first_room) begin
									cnt1_q <= cnt1_q + 1'b1;
								end else begin
									dropped_q <= 1'b1;
								end
							end
							mosl_pkg::OP_APPEND_SECOND: begin
								if (second_room) begin
									cnt2_q <= cnt2_q + 1'b1;
								end else begin
									dropped_q <= 1'b1;
								end
							end
							mosl_pkg::OP_MEDIAN: begin
								i1_q    <= '0;
								i2_q    <= '0;
								k_q     <= '0;
								mid_q   <= total[TW-1:1];
								odd_q   <= total[0];
								empty_q <= (total == '0);
								state_q <= (total == '0) ? ST_FIN : ST_WALK;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					i1_q <= i1_next;
					i2_q <= i2_next;
					if (k_q == mid_q) begin
						state_q <= ST_FIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (load_out) begin
						cnt1_q    <= '0;
						cnt2_q    <= '0;
						dropped_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid    = out_valid_q;
	assign result.median   = median_q;
	assign result.has_half = half_q;
	assign result.status   = status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt1_q <= CW'(mosl_pkg::LIST_DEPTH)) && (cnt2_q <= CW'(mosl_pkg::LIST_DEPTH)))
		else $error("list count beyond depth");

	a_walk_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> ((i1_q + i2_q) == k_q) && (k_q <= mid_q))
		else $error("merge walk indices out of step");

	a_clear_after: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (cnt1_q == '0) && (cnt2_q == '0) && !dropped_q && out_valid_q)
		else $error("lists not cleared after a result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> (out_valid_q && $stable(median_q)))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== rtl/median_of_two_sorted_lists_core.sv =====
// top level of the median-of-two-sorted-lists block
// depends on mosl_pkg, mosl_item_if, mosl_result_if, mosl_front, mosl_queue, mosl_back
//
// usage
//   item channel: command 0 appends value to the first list, 1 to the second,
//   2 asks for the median of both lists and then empties them; code 3 is
//   taken and ignored. lists are expected in ascending order, not checked
//   result channel: one word per median command with median, has_half and
//   status (ok, both lists empty, or some append dropped because full)
// timing
//   appends go in one a cycle while the queue has room; the front end decodes,
//   a four-word queue buffers, and the idle list engine writes one append a
//   cycle and issues the first memory reads; a median command holds the list
//   engine for mid + 1 merge steps (one per cycle, set by the single read port
//   of each list memory), mid being half the combined count, and for the mean,
//   which goes to the result register once that is free; the result appears
//   the cycle after. while the engine is busy, new words collect in the queue
//   and the item channel stalls once it fills
// reset and stall
//   reset empties both lists, clears the dropped flag and the queue; list
//   memories keep stale data, which is never used past the fill counts
//   a stalled result receiver holds the result register; appends keep
//   being taken, and the next median waits until the pending word is taken
`default_nettype none

module median_of_two_sorted_lists_core (
	input  logic           clk,
	input  logic           arst_n,
	mosl_item_if.sink      item,
	mosl_result_if.source  result
);

	// front end to queue
	logic              push_valid;
	logic              push_ready;
	mosl_pkg::job_t    push_job;

	// queue to list engine
	logic              job_valid;
	logic              job_ready;
	mosl_pkg::job_t    job;

	mosl_front u_front (
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// decouples decode from the multi-cycle merge walk
	mosl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (job_valid),
		.pop_ready  (job_ready),
		.pop_job    (job)
	);

	// list memories, merge walk and result register
	mosl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.result    (result)
	);

endmodule

`default_nettype wire
